[rtl/accel_sample_average_bias_scale_core_defines.svh]
// assertion macros shared by the accel averaging core
// no dependencies; included by the controller and datapath files
`ifndef ACCEL_SAMPLE_AVERAGE_BIAS_SCALE_CORE_DEFINES_SVH
`define ACCEL_SAMPLE_AVERAGE_BIAS_SCALE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASABS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASABS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASABS_ASSERT(lbl, clk, rst, prop, msg)
`define ASABS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/asabs_pkg.sv]
// shared types and constants for the accel averaging core
// no dependencies; used by asabs_ctrl, asabs_dp and the top level
package asabs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BIAS_W     = 16;
  localparam int SUM_W      = 24;
  localparam int COUNT_W    = 8;
  localparam int SCALE_W    = 24;
  localparam int OUT_W      = 24;
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;
  localparam int VAL_W      = 17;
  localparam int PROD_W     = VAL_W + SCALE_W + 1;
  localparam int REM_W      = COUNT_W + 1;
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int ROUND_SHIFT = 8;

  localparam int MAX_SAMPLES_DEFAULT = 255;
  localparam int COUNT_CAP           = 255;

  localparam logic [SCALE_W-1:0]       SCALE_RESET = 24'd20091;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS  = PROD_W'(128);
  localparam logic signed [OUT_W-1:0]  OUT_MAX     = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0]  OUT_MIN     = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS_X,
    REG_BIAS_Y,
    REG_BIAS_Z,
    REG_SCALE
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE,
    OP_EVAL
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BIAS,
    ST_MUL,
    ST_RND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              acc_en;
    logic              eval_load;
    logic              div_step;
    logic              bias_en;
    logic              mul_en;
    logic              rnd_en;
    logic [AXIS_W-1:0] axis;
    logic              out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_busy;
  } dp_status_t;

endpackage

[rtl/asabs_ctrl.sv]
// controller state machine for the accel averaging core
// depends on asabs_pkg and the shared assertion macro header
`include "accel_sample_average_bias_scale_core_defines.svh"

module asabs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   opcode,
  output logic                   in_stall,
  input  asabs_pkg::dp_status_t  sts,
  output asabs_pkg::ctrl_cmd_t   cmd
);

  asabs_pkg::state_t state, state_next;
  logic [asabs_pkg::STEP_W-1:0] step;
  logic [asabs_pkg::AXIS_W-1:0] axis;
  logic eval_acc;

  assign eval_acc = (state == asabs_pkg::ST_IDLE) && in_valid &&
                    (opcode == asabs_pkg::OP_EVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asabs_pkg::ST_IDLE;
      step  <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      if (state == asabs_pkg::ST_DIV) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      if (state == asabs_pkg::ST_BIAS) begin
        axis <= '0;
      end else if (state == asabs_pkg::ST_RND) begin
        axis <= axis + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      asabs_pkg::ST_IDLE: begin
        if (eval_acc) begin
          state_next = sts.cnt_zero ? asabs_pkg::ST_DONE : asabs_pkg::ST_DIV;
        end
      end
      asabs_pkg::ST_DIV: begin
        if (step == asabs_pkg::STEP_W'(asabs_pkg::DIV_STEPS - 1)) begin
          state_next = asabs_pkg::ST_BIAS;
        end
      end
      asabs_pkg::ST_BIAS: state_next = asabs_pkg::ST_MUL;
      asabs_pkg::ST_MUL:  state_next = asabs_pkg::ST_RND;
      asabs_pkg::ST_RND: begin
        if (axis == asabs_pkg::AXIS_W'(asabs_pkg::AXES - 1)) begin
          state_next = asabs_pkg::ST_DONE;
        end else begin
          state_next = asabs_pkg::ST_MUL;
        end
      end
      asabs_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          state_next = asabs_pkg::ST_IDLE;
        end
      end
      default: state_next = asabs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != asabs_pkg::ST_IDLE);
    cmd.acc_en    = (state == asabs_pkg::ST_IDLE) && in_valid &&
                    (opcode == asabs_pkg::OP_SAMPLE);
    cmd.eval_load = eval_acc;
    cmd.div_step  = (state == asabs_pkg::ST_DIV);
    cmd.bias_en   = (state == asabs_pkg::ST_BIAS);
    cmd.mul_en    = (state == asabs_pkg::ST_MUL);
    cmd.rnd_en    = (state == asabs_pkg::ST_RND);
    cmd.axis      = axis;
    cmd.out_load  = (state == asabs_pkg::ST_DONE) && !sts.out_busy;
  end

  `ASABS_ASSERT(a_eval_starts_div, clk, rst, (eval_acc && !sts.cnt_zero) |=> (state == asabs_pkg::ST_DIV), "evaluate with samples did not start the divider")
  `ASABS_ASSERT(a_load_when_free, clk, rst, cmd.out_load |-> !sts.out_busy, "result loaded over a waiting transaction")
  `ASABS_ASSERT(a_bias_then_axis0, clk, rst, (state == asabs_pkg::ST_BIAS) |=> (state == asabs_pkg::ST_MUL && axis == '0), "scaling did not start at the first axis")

endmodule

[rtl/asabs_dp.sv]
// datapath of the accel averaging core: accumulators, three restoring
// dividers, bias add, shared multiplier, round and saturate, output register
// depends on asabs_pkg and the shared assertion macro header
`include "accel_sample_average_bias_scale_core_defines.svh"

module asabs_dp #(
  parameter int MAX_SAMPLES = asabs_pkg::MAX_SAMPLES_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  asabs_pkg::ctrl_cmd_t                   cmd,
  output asabs_pkg::dp_status_t                  sts,
  input  logic                                   cfg_we,
  input  logic [asabs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [asabs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [asabs_pkg::SAMPLE_W-1:0]  sample_x,
  input  logic signed [asabs_pkg::SAMPLE_W-1:0]  sample_y,
  input  logic signed [asabs_pkg::SAMPLE_W-1:0]  sample_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [asabs_pkg::OUT_W-1:0]     accel_x,
  output logic signed [asabs_pkg::OUT_W-1:0]     accel_y,
  output logic signed [asabs_pkg::OUT_W-1:0]     accel_z,
  output logic [asabs_pkg::COUNT_W-1:0]          sample_count,
  output logic                                   empty_res,
  output logic                                   saturated
);

  localparam logic [asabs_pkg::COUNT_W-1:0] COUNT_LIMIT = asabs_pkg::COUNT_W'(
    (MAX_SAMPLES > asabs_pkg::COUNT_CAP) ? asabs_pkg::COUNT_CAP : MAX_SAMPLES);

  logic signed [asabs_pkg::BIAS_W-1:0]   bias [asabs_pkg::AXES];
  logic [asabs_pkg::SCALE_W-1:0]         scale;
  logic signed [asabs_pkg::SAMPLE_W-1:0] samp [asabs_pkg::AXES];

  logic signed [asabs_pkg::SUM_W-1:0] sum [asabs_pkg::AXES];
  logic [asabs_pkg::COUNT_W-1:0]      count;
  logic                               overflowed;

  logic [asabs_pkg::SUM_W-1:0]   quo [asabs_pkg::AXES];
  logic [asabs_pkg::REM_W-1:0]   rem [asabs_pkg::AXES];
  logic                          neg [asabs_pkg::AXES];
  logic [asabs_pkg::COUNT_W-1:0] cnt_snap;
  logic                          ovf_snap;
  logic                          empty_snap;

  logic signed [asabs_pkg::VAL_W-1:0]  val [asabs_pkg::AXES];
  logic signed [asabs_pkg::PROD_W-1:0] prod;
  logic signed [asabs_pkg::OUT_W-1:0]  res [asabs_pkg::AXES];

  logic [asabs_pkg::REM_W-1:0]         rem_sh  [asabs_pkg::AXES];
  logic                                rem_ge  [asabs_pkg::AXES];
  logic signed [asabs_pkg::VAL_W-1:0]  avg     [asabs_pkg::AXES];
  logic signed [asabs_pkg::VAL_W-1:0]  val_calc [asabs_pkg::AXES];
  logic signed [asabs_pkg::PROD_W-1:0] prod_calc;
  logic signed [asabs_pkg::PROD_W-1:0] rnd_sum;
  logic signed [asabs_pkg::PROD_W-1:0] rnd_shift;
  logic signed [asabs_pkg::OUT_W-1:0]  sat_val;

  assign samp[0] = sample_x;
  assign samp[1] = sample_y;
  assign samp[2] = sample_z;

  assign sts.cnt_zero = (count == '0);
  assign sts.out_busy = out_valid && out_stall;

  always_comb begin
    for (int i = 0; i < asabs_pkg::AXES; i++) begin
      rem_sh[i] = {rem[i][asabs_pkg::REM_W-2:0], quo[i][asabs_pkg::SUM_W-1]};
      rem_ge[i] = (rem_sh[i] >= {1'b0, cnt_snap});
      // quotient magnitude never exceeds 32768, so 17 bits hold it
      avg[i] = neg[i] ? -$signed(quo[i][asabs_pkg::VAL_W-1:0])
                      : $signed(quo[i][asabs_pkg::VAL_W-1:0]);
      val_calc[i] = avg[i] + asabs_pkg::VAL_W'(bias[i]);
    end
  end

  assign prod_calc = val[cmd.axis] * $signed({1'b0, scale});
  // round to nearest, ties toward plus infinity
  assign rnd_sum   = prod + asabs_pkg::ROUND_BIAS;
  assign rnd_shift = rnd_sum >>> asabs_pkg::ROUND_SHIFT;

  always_comb begin
    if (rnd_shift > asabs_pkg::PROD_W'(asabs_pkg::OUT_MAX)) begin
      sat_val = asabs_pkg::OUT_MAX;
    end else if (rnd_shift < asabs_pkg::PROD_W'(asabs_pkg::OUT_MIN)) begin
      sat_val = asabs_pkg::OUT_MIN;
    end else begin
      sat_val = rnd_shift[asabs_pkg::OUT_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < asabs_pkg::AXES; i++) begin
        bias[i] <= '0;
      end
      scale <= asabs_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (asabs_pkg::cfg_reg_t'(cfg_index))
        asabs_pkg::REG_BIAS_X: bias[0] <= cfg_data[asabs_pkg::BIAS_W-1:0];
        asabs_pkg::REG_BIAS_Y: bias[1] <= cfg_data[asabs_pkg::BIAS_W-1:0];
        asabs_pkg::REG_BIAS_Z: bias[2] <= cfg_data[asabs_pkg::BIAS_W-1:0];
        asabs_pkg::REG_SCALE:  scale   <= cfg_data[asabs_pkg::SCALE_W-1:0];
      endcase
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < asabs_pkg::AXES; i++) begin
        sum[i] <= '0;
      end
      count      <= '0;
      overflowed <= 1'b0;
    end else if (cmd.eval_load) begin
      for (int i = 0; i < asabs_pkg::AXES; i++) begin
        sum[i] <= '0;
      end
      count      <= '0;
      overflowed <= 1'b0;
    end else if (cmd.acc_en) begin
      if (count >= COUNT_LIMIT) begin
        overflowed <= 1'b1;
      end else begin
        for (int i = 0; i < asabs_pkg::AXES; i++) begin
          sum[i] <= sum[i] + asabs_pkg::SUM_W'(samp[i]);
        end
        count <= count + 1'b1;
      end
    end
  end

  // divider, bias add, multiply, round
  always_ff @(posedge clk) begin
    if (cmd.eval_load) begin
      for (int i = 0; i < asabs_pkg::AXES; i++) begin
        neg[i] <= sum[i][asabs_pkg::SUM_W-1];
        quo[i] <= sum[i][asabs_pkg::SUM_W-1] ? -sum[i] : sum[i];
        rem[i] <= '0;
      end
      cnt_snap   <= count;
      ovf_snap   <= overflowed;
      empty_snap <= (count == '0);
    end else if (cmd.div_step) begin
      for (int i = 0; i < asabs_pkg::AXES; i++) begin
        rem[i] <= rem_ge[i] ? (rem_sh[i] - {1'b0, cnt_snap}) : rem_sh[i];
        quo[i] <= {quo[i][asabs_pkg::SUM_W-2:0], rem_ge[i]};
      end
    end
    if (cmd.bias_en) begin
      for (int i = 0; i < asabs_pkg::AXES; i++) begin
        val[i] <= val_calc[i];
      end
    end
    if (cmd.mul_en) begin
      prod <= prod_calc;
    end
    if (cmd.rnd_en) begin
      res[cmd.axis] <= sat_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accel_x      <= empty_snap ? '0 : res[0];
      accel_y      <= empty_snap ? '0 : res[1];
      accel_z      <= empty_snap ? '0 : res[2];
      sample_count <= cnt_snap;
      empty_res    <= empty_snap;
      saturated    <= ovf_snap;
    end
  end

  `ASABS_ASSERT(a_rem_below_divisor, clk, rst, cmd.div_step |=> (rem[0] < {1'b0, cnt_snap}), "divider remainder not below the count")
  `ASABS_ASSERT(a_count_in_limit, clk, rst, count <= COUNT_LIMIT, "sample count beyond its limit")
  `ASABS_ASSERT(a_eval_clears, clk, rst, cmd.eval_load |=> (count == '0 && !overflowed), "evaluate did not clear the accumulators")

endmodule

[rtl/accel_sample_average_bias_scale_core.sv]
// channel     | dir | handshake            | payload
// input       | in  | in_valid / in_stall  | opcode, sample_x, sample_y, sample_z
// result      | out | out_valid / out_stall| accel_x/y/z, sample_count, empty_res, saturated
// config      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a sample is taken whenever the core is idle; samples may arrive back to back
// an evaluate with samples runs these steps before the next transaction is taken:
// 24 steps of the restoring dividers, one bias add, three multiply/round pairs
// on the shared 17x25 multiplier and one output load; an empty evaluate loads zeros
// rst is synchronous: clears accumulators, bias registers and output valid, loads scale
// a stalled result holds the output register and with it the finishing evaluate
// top level of the accel averaging core: controller and datapath joined by commands
// depends on asabs_pkg, asabs_ctrl and asabs_dp
module accel_sample_average_bias_scale_core #(
  parameter int MAX_SAMPLES = asabs_pkg::MAX_SAMPLES_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   opcode,
  input  logic signed [asabs_pkg::SAMPLE_W-1:0]  sample_x,
  input  logic signed [asabs_pkg::SAMPLE_W-1:0]  sample_y,
  input  logic signed [asabs_pkg::SAMPLE_W-1:0]  sample_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [asabs_pkg::OUT_W-1:0]     accel_x,
  output logic signed [asabs_pkg::OUT_W-1:0]     accel_y,
  output logic signed [asabs_pkg::OUT_W-1:0]     accel_z,
  output logic [asabs_pkg::COUNT_W-1:0]          sample_count,
  output logic                                   empty_res,
  output logic                                   saturated,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [asabs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [asabs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  asabs_pkg::ctrl_cmd_t  cmd;
  asabs_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  asabs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  asabs_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .sample_z     (sample_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .sample_count (sample_count),
    .empty_res    (empty_res),
    .saturated    (saturated)
  );

endmodule
